FILE: rtl/apa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apa_pkg
// Shared types and constants of the address pool allocator.
// ----------------------------------------------------------------------------
package apa_pkg;

  localparam int DEFAULT_NET_BYTES = 3;
  localparam int BITS_PER_BYTE     = 8;
  localparam int ADDR_W            = 32;
  localparam int COUNT_W           = 9;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    RS_OK        = 2'd0,
    RS_FAIL      = 2'd1,
    RS_NOT_AVAIL = 2'd2,
    RS_WRONG_NET = 2'd3
  } rsp_status_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DESC_RD,
    ST_DESC_EV,
    ST_BACK,
    ST_FREE_RD,
    ST_FREE_EV,
    ST_FIX_RD,
    ST_FIX_EV,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_START,
    CMD_DESC_RD,
    CMD_DESC_EV,
    CMD_BACK,
    CMD_FREE_RD,
    CMD_FREE_EV,
    CMD_FIX_RD,
    CMD_FIX_EV,
    CMD_LOAD_OUT
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic early;
    logic is_free;
    logic rd_full;
    logic at_leaf;
    logic at_root;
    logic is_left;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/apa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apa_if
// Request and response channels of the address pool allocator.
// ----------------------------------------------------------------------------
interface apa_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        use_request;
  logic [31:0] requested_address;

  modport source (output valid, opcode, use_request, requested_address, input ready);
  modport sink (input valid, opcode, use_request, requested_address, output ready);
endinterface

interface apa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] granted_address;
  logic [8:0]  free_count;

  modport source (output valid, status, granted_address, free_count, input ready);
  modport sink (input valid, status, granted_address, free_count, output ready);
endinterface

FILE: rtl/apa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apa_ctrl
// Sequencer for clearing pass, tree descent, backtrack and ancestor update.
// ----------------------------------------------------------------------------
module apa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  apa_pkg::dp_stat_t stat,
  output apa_pkg::cmd_t     cmd
);

  apa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apa_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = apa_pkg::CMD_NONE;
    req_ready  = 1'b0;
    unique case (state)
      apa_pkg::ST_INIT: begin
        cmd = apa_pkg::CMD_INIT;
        if (stat.init_last) state_next = apa_pkg::ST_IDLE;
      end
      apa_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd = apa_pkg::CMD_START;
          if (stat.early) state_next = apa_pkg::ST_DONE;
          else if (stat.is_free) state_next = apa_pkg::ST_FREE_RD;
          else state_next = apa_pkg::ST_DESC_RD;
        end
      end
      apa_pkg::ST_DESC_RD: begin
        cmd        = apa_pkg::CMD_DESC_RD;
        state_next = apa_pkg::ST_DESC_EV;
      end
      apa_pkg::ST_DESC_EV: begin
        cmd = apa_pkg::CMD_DESC_EV;
        if (stat.rd_full) state_next = apa_pkg::ST_BACK;
        else if (stat.at_leaf) state_next = apa_pkg::ST_FIX_RD;
        else state_next = apa_pkg::ST_DESC_RD;
      end
      apa_pkg::ST_BACK: begin
        cmd = apa_pkg::CMD_BACK;
        if (stat.at_root) state_next = apa_pkg::ST_DONE;
        else if (stat.is_left) state_next = apa_pkg::ST_DESC_RD;
      end
      apa_pkg::ST_FREE_RD: begin
        cmd        = apa_pkg::CMD_FREE_RD;
        state_next = apa_pkg::ST_FREE_EV;
      end
      apa_pkg::ST_FREE_EV: begin
        cmd        = apa_pkg::CMD_FREE_EV;
        state_next = stat.rd_full ? apa_pkg::ST_FIX_RD : apa_pkg::ST_DONE;
      end
      apa_pkg::ST_FIX_RD: begin
        cmd        = apa_pkg::CMD_FIX_RD;
        state_next = stat.at_root ? apa_pkg::ST_DONE : apa_pkg::ST_FIX_EV;
      end
      apa_pkg::ST_FIX_EV: begin
        cmd        = apa_pkg::CMD_FIX_EV;
        state_next = apa_pkg::ST_FIX_RD;
      end
      apa_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd        = apa_pkg::CMD_LOAD_OUT;
          state_next = apa_pkg::ST_IDLE;
        end
      end
      default: state_next = apa_pkg::ST_INIT;
    endcase
  end

endmodule

FILE: rtl/apa_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apa_dpath
// Full-flag tree memory, walk registers, free count and output register.
// ----------------------------------------------------------------------------
module apa_dpath #(
  parameter int NET_BYTES = apa_pkg::DEFAULT_NET_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  apa_pkg::cmd_t     cmd,
  output apa_pkg::dp_stat_t stat,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  logic              in_opcode,
  input  logic              in_use_request,
  input  logic [31:0]       in_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [31:0]       out_granted,
  output logic [8:0]        out_count
);

  localparam int HOST_BITS = (4 - NET_BYTES) * apa_pkg::BITS_PER_BYTE;
  localparam int NODE_W    = HOST_BITS + 1;
  localparam int LVL_W     = $clog2(HOST_BITS + 1);
  localparam int CNT_W     = HOST_BITS + 1;
  localparam int TREE_SIZE = 2 << HOST_BITS;
  localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(1) << HOST_BITS;
  localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);
  localparam logic [31:0] HOST_MASK = (32'd1 << HOST_BITS) - 32'd1;
  localparam logic [31:0] NET_MASK  = ~HOST_MASK;
  localparam logic [CNT_W-1:0] FREE_AT_RESET = CNT_W'((1 << HOST_BITS) - 3);

  logic                 mem [TREE_SIZE];
  logic                 rdata;
  logic                 we;
  logic [NODE_W-1:0]    wa;
  logic                 wd;
  logic [NODE_W-1:0]    rd_addr;

  logic [31:0]          prefix;
  logic [NODE_W-1:0]    init_ptr;
  logic [NODE_W-1:0]    node;
  logic [LVL_W-1:0]     lvl;
  logic [HOST_BITS-1:0] want;
  logic                 fill_v;
  logic [1:0]           res_status;
  logic [31:0]          granted;
  logic [CNT_W-1:0]     count;

  logic [31:0]          pre;
  logic                 net_ok;
  logic                 reserved;
  logic [1:0]           chk_status;
  logic                 want_bit;
  logic [HOST_BITS-1:0] want_skip;
  logic                 init_val;
  logic [CNT_W+8:0]     count_wide;

  assign pre      = prefix & NET_MASK;
  assign net_ok   = (in_address & pre) == pre;
  assign reserved = (in_address == pre) || (in_address == (pre | HOST_MASK)) ||
                    (in_address == (pre | (HOST_MASK - 32'd1)));

  always_comb begin
    chk_status = apa_pkg::RS_OK;
    if (in_opcode == apa_pkg::OP_FREE) begin
      if (reserved) chk_status = apa_pkg::RS_FAIL;
      else if (!net_ok) chk_status = apa_pkg::RS_WRONG_NET;
    end else if (in_use_request && !net_ok) begin
      chk_status = apa_pkg::RS_WRONG_NET;
    end
  end

  // bit of the wanted host that picks the child below the current node
  always_comb begin
    want_bit  = 1'b0;
    want_skip = want;
    for (int i = 0; i < HOST_BITS; i++) begin
      if (LVL_W'(i + 1) == lvl) want_bit = want[i];
      if (LVL_W'(i) == lvl) want_skip[i] = 1'b1;
      else if (LVL_W'(i) < lvl) want_skip[i] = 1'b0;
    end
  end

  // reserved leaves and the one parent whose children are both reserved
  assign init_val = (init_ptr == LEAF_BASE) || (init_ptr == LEAF_BASE - NODE_W'(1)) ||
                    (init_ptr == '1) || (init_ptr == ('1 - NODE_W'(1)));

  assign count_wide = {9'd0, count};

  always_comb begin
    stat.init_last = init_ptr == '1;
    stat.early     = chk_status != apa_pkg::RS_OK;
    stat.is_free   = in_opcode == apa_pkg::OP_FREE;
    stat.rd_full   = rdata;
    stat.at_leaf   = lvl == '0;
    stat.at_root   = node == ROOT;
    stat.is_left   = !node[0];
    stat.out_free  = !out_valid || out_ready;
  end

  assign rd_addr = (cmd == apa_pkg::CMD_FIX_RD) ? (node ^ NODE_W'(1)) : node;

  always_comb begin
    we = 1'b0;
    wa = node;
    wd = 1'b0;
    case (cmd)
      apa_pkg::CMD_INIT: begin
        we = 1'b1;
        wa = init_ptr;
        wd = init_val;
      end
      apa_pkg::CMD_DESC_EV: begin
        we = !rdata && (lvl == '0);
        wd = 1'b1;
      end
      apa_pkg::CMD_FREE_EV: begin
        we = rdata;
      end
      apa_pkg::CMD_FIX_EV: begin
        we = 1'b1;
        wa = node >> 1;
        wd = fill_v & rdata;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix    <= '0;
      init_ptr  <= '0;
      count     <= FREE_AT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) prefix <= cfg_data;
      if (cmd == apa_pkg::CMD_INIT) init_ptr <= init_ptr + NODE_W'(1);
      if (cmd == apa_pkg::CMD_DESC_EV && !rdata && lvl == '0) count <= count - CNT_W'(1);
      if (cmd == apa_pkg::CMD_FREE_EV && rdata) count <= count + CNT_W'(1);
      if (cmd == apa_pkg::CMD_LOAD_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      apa_pkg::CMD_START: begin
        res_status <= chk_status;
        granted    <= '0;
        fill_v     <= in_opcode == apa_pkg::OP_ALLOC;
        lvl        <= LVL_W'(HOST_BITS);
        if (in_opcode == apa_pkg::OP_FREE) begin
          node <= {1'b1, in_address[HOST_BITS-1:0]};
        end else begin
          node <= ROOT;
        end
        want <= in_use_request ? in_address[HOST_BITS-1:0] : '0;
      end
      apa_pkg::CMD_DESC_EV: begin
        if (!rdata) begin
          if (lvl == '0) begin
            granted <= pre | {{(32 - HOST_BITS){1'b0}}, node[HOST_BITS-1:0]};
          end else begin
            node <= {node[NODE_W-2:0], want_bit};
            lvl  <= lvl - LVL_W'(1);
          end
        end
      end
      apa_pkg::CMD_BACK: begin
        if (node == ROOT) begin
          res_status <= apa_pkg::RS_NOT_AVAIL;
        end else if (!node[0]) begin
          // retry from the lowest host of the right sibling
          node <= node | NODE_W'(1);
          want <= want_skip;
        end else begin
          node <= node >> 1;
          lvl  <= lvl + LVL_W'(1);
        end
      end
      apa_pkg::CMD_FREE_EV: begin
        if (!rdata) res_status <= apa_pkg::RS_FAIL;
      end
      apa_pkg::CMD_FIX_EV: begin
        fill_v <= fill_v & rdata;
        node   <= node >> 1;
      end
      apa_pkg::CMD_LOAD_OUT: begin
        out_status  <= res_status;
        out_granted <= granted;
        out_count   <= count_wide[8:0];
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/address_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_pool_allocator
// Hands out and takes back host addresses under one network prefix.
// ----------------------------------------------------------------------------
// Usage: req carries an allocate or free item, rsp returns one result item
// (status, granted address, free count) per request. cfg_we/cfg_data write
// the network prefix; write it only while the block is idle.
// Full flags live in a binary tree memory of 2^(H+1) one-bit nodes, with
// H host bits (8 by default). One item is taken at a time.
// The tree walk reads and then evaluates each node that it visits:
//   allocate: descent from the root to a free leaf, then ancestor update;
//   on a full node the search backs up and re-descends into a right subtree
//   free: leaf check, then ancestor update; a free of a host that is not
//   taken ends after the leaf check; rejected items skip the tree walk
// The next item can be accepted in the cycle after a result is loaded.
// After reset a clearing pass over every tree node loads the reserved
// hosts; req.ready stays low during it. Reset also clears the prefix and
// sets the free count to 2^H - 3.
// A finished result sits in an output register; when rsp stalls, the block
// still accepts and works the next item and holds its result until rsp drains.
// ----------------------------------------------------------------------------
module address_pool_allocator #(
  parameter int NET_BYTES = apa_pkg::DEFAULT_NET_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  apa_req_if.sink    req,
  apa_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic [31:0] cfg_data
);

  apa_pkg::cmd_t     cmd;
  apa_pkg::dp_stat_t stat;

  apa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  apa_dpath #(
    .NET_BYTES (NET_BYTES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_opcode      (req.opcode),
    .in_use_request (req.use_request),
    .in_address     (req.requested_address),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_status     (rsp.status),
    .out_granted    (rsp.granted_address),
    .out_count      (rsp.free_count)
  );

endmodule

FILE: rtl/apa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apa_checker
// Port-level checks of the address pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module apa_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [31:0] granted_address
);

  // one item in work at a time
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while an item is in work");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != apa_pkg::RS_OK) |-> (granted_address == 32'd0))
    else $error("address granted on a failed item");

  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result shown right after reset");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) &&
                                   $stable(granted_address)))
    else $error("stalled result changed");

endmodule

bind address_pool_allocator apa_checker u_apa_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .status          (rsp.status),
  .granted_address (rsp.granted_address)
);

FILE: tb/address_pool_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_pool_allocator_test
// Drives allocate and free items under several network prefixes and checks
// each result against a model of the host pool kept inside the bench.
// ----------------------------------------------------------------------------
module address_pool_allocator_test;

  localparam int HOST_BITS = (4 - apa_pkg::DEFAULT_NET_BYTES) * apa_pkg::BITS_PER_BYTE;
  localparam int NUM_HOSTS = 1 << HOST_BITS;
  localparam logic [31:0] HOST_MASK = 32'(NUM_HOSTS - 1);
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    apa_pkg::rsp_status_t status;
    logic [31:0] granted;
    logic [8:0]  count;
  } pool_result_t;

  // pool model and queue of expected result items
  class pool_scoreboard;
    bit          taken[NUM_HOSTS];
    int unsigned free_hosts;
    logic [31:0] prefix;
    pool_result_t pending[$];
    int errors;

    function void clear();
      foreach (taken[i]) taken[i] = 0;
      taken[0] = 1;
      taken[NUM_HOSTS - 1] = 1;
      taken[NUM_HOSTS - 2] = 1;
      free_hosts = NUM_HOSTS - 3;
      prefix = '0;
    endfunction

    function void note_request(apa_pkg::opcode_t op, logic use_req, logic [31:0] addr);
      pool_result_t r;
      logic [31:0] pre;
      int h;
      pre = prefix & ~HOST_MASK;
      r.status = apa_pkg::RS_OK;
      r.granted = '0;
      if (op == apa_pkg::OP_ALLOC) begin
        if (use_req && (addr & pre) != pre) begin
          r.status = apa_pkg::RS_WRONG_NET;
        end else begin
          // lowest free host at or above the start
          h = use_req ? int'(addr & HOST_MASK) : 0;
          while (h < NUM_HOSTS && taken[h]) h++;
          if (h < NUM_HOSTS) begin
            taken[h] = 1;
            free_hosts--;
            r.granted = pre | 32'(h);
          end else begin
            r.status = apa_pkg::RS_NOT_AVAIL;
          end
        end
      end else begin
        if (addr == pre || addr == (pre | HOST_MASK) || addr == (pre | (HOST_MASK - 32'd1)))
          r.status = apa_pkg::RS_FAIL;
        else if ((addr & pre) != pre)
          r.status = apa_pkg::RS_WRONG_NET;
        else if (!taken[addr & HOST_MASK])
          r.status = apa_pkg::RS_FAIL;
        else begin
          taken[addr & HOST_MASK] = 0;
          free_hosts++;
        end
      end
      r.count = free_hosts[8:0];
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [31:0] ga, logic [8:0] fc);
      pool_result_t e;
      if (pending.size() == 0) begin
        report("unexpected item", 32'(st), 32'd0);
        return;
      end
      e = pending.pop_front();
      if (st != e.status) report("status", 32'(st), 32'(e.status));
      if (ga != e.granted) report("granted_address", ga, e.granted);
      if (fc != e.count) report("free_count", 32'(fc), 32'(e.count));
    endtask
  endclass

  logic clk, rst, cfg_we;
  logic [31:0] cfg_data;
  apa_req_if req();
  apa_rsp_if rsp();
  pool_scoreboard pool;
  int cycles = 0;
  int hold_off;
  bit random_stall;

  address_pool_allocator dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("address_pool_allocator test failed");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // result side: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      pool.check_result(rsp.status, rsp.granted_address, rsp.free_count);
  end

  initial begin
    int g;
    rsp.ready = 0;
    @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        rsp.ready <= 0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      g = random_stall ? gap_len() : 0;
      if (g > 0) begin
        rsp.ready <= 0;
        repeat (g) @(negedge clk);
      end
      rsp.ready <= 1;
      @(negedge clk);
    end
  end

  // valid stays high after acceptance until the next call or an idle point
  task send_item(apa_pkg::opcode_t op, logic use_req, logic [31:0] addr);
    int g;
    g = random_stall ? gap_len() : 0;
    if (g > 0) begin
      req.valid <= 0;
      repeat (g) @(negedge clk);
    end
    req.valid <= 1;
    req.opcode <= op;
    req.use_request <= use_req;
    req.requested_address <= addr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pool.note_request(op, use_req, addr);
    @(negedge clk);
  endtask

  task drain_and_set_prefix(logic [31:0] value);
    req.valid <= 0;
    while (pool.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we <= 1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 0;
    pool.prefix = value;
  endtask

  function automatic logic [31:0] pick_addr(logic [31:0] pre);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return (pre | HOST_MASK) - ($urandom_range(0, 1) ? 32'h0 : 32'h1);
    return (pre & ~HOST_MASK) | $urandom_range(0, NUM_HOSTS - 1);
  endfunction

  task random_phase(int n);
    logic [31:0] pre;
    int k;
    pre = pool.prefix & ~HOST_MASK;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 1))
        send_item(apa_pkg::OP_ALLOC, 1'($urandom_range(0, 1)), pick_addr(pre));
      else
        send_item(apa_pkg::OP_FREE, 1'($urandom_range(0, 1)), pick_addr(pre));
    end
  endtask

  initial begin
    logic [31:0] pre;
    int k;
    pool = new();
    pool.clear();
    pool.errors = 0;
    hold_off = 0;
    random_stall = 0;
    rst = 1;
    cfg_we = 0;
    cfg_data = '0;
    req.valid = 0;
    req.opcode = apa_pkg::OP_ALLOC;
    req.use_request = 0;
    req.requested_address = '0;
    repeat (10) @(negedge clk);
    rst <= 0;

    // directed: prefix zero, extremes and every special case but an exhausted pool
    send_item(apa_pkg::OP_ALLOC, 0, 32'h0);
    send_item(apa_pkg::OP_ALLOC, 1, 32'hFFFF_FFFD);
    send_item(apa_pkg::OP_ALLOC, 1, 32'h0000_00FD);
    send_item(apa_pkg::OP_FREE, 0, 32'h0);
    send_item(apa_pkg::OP_FREE, 1, 32'hFF);
    send_item(apa_pkg::OP_FREE, 0, 32'hFE);
    send_item(apa_pkg::OP_FREE, 0, 32'h1);
    send_item(apa_pkg::OP_FREE, 0, 32'h1);
    send_item(apa_pkg::OP_FREE, 0, 32'h77);
    drain_and_set_prefix(32'hFFFF_FFFF);
    pre = 32'hFFFF_FF00;
    send_item(apa_pkg::OP_ALLOC, 1, 32'h0000_0010);
    send_item(apa_pkg::OP_FREE, 0, 32'h0000_0001);
    send_item(apa_pkg::OP_FREE, 0, pre);
    send_item(apa_pkg::OP_FREE, 0, 32'hFFFF_FFFF);
    send_item(apa_pkg::OP_ALLOC, 1, 32'hFFFF_FF80);
    send_item(apa_pkg::OP_FREE, 1, 32'hFFFF_FF80);
    send_item(apa_pkg::OP_ALLOC, 1, 32'hFFFF_FFFE);
    drain_and_set_prefix(32'h0A0B_0C5A);

    // long hold-off while requests keep coming
    random_stall = 1;
    hold_off = 300;
    random_phase(20);
    drain_and_set_prefix(32'hC0A8_0100);
    // fill the pool to exhaustion, then release
    for (k = 0; k < 260; k++) send_item(apa_pkg::OP_ALLOC, 0, $urandom);
    random_phase(20);
    for (k = 1; k < NUM_HOSTS - 2; k++)
      if ($urandom_range(0, 3) == 0) send_item(apa_pkg::OP_FREE, 0, 32'hC0A8_0100 | 32'(k));
    drain_and_set_prefix($urandom);
    random_phase(20);
    drain_and_set_prefix(32'h8000_0000);
    random_phase(20);

    req.valid <= 0;
    while (pool.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (pool.errors == 0) begin
      $display("address_pool_allocator test passed");
    end else begin
      $display("address_pool_allocator test failed");
    end
    $finish;
  end
endmodule

FILE: address_pool_allocator.f
rtl/apa_pkg.sv
rtl/apa_if.sv
rtl/apa_ctrl.sv
rtl/apa_dpath.sv
rtl/address_pool_allocator.sv
rtl/apa_checker.sv
tb/address_pool_allocator_test.sv
